@@ rtl/core/tcdf_pkg.sv @@
package tcdf_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_TICK   = 2'd0;
   localparam op_type OP_SWITCH = 2'd1;
   localparam op_type OP_LEVEL  = 2'd2;

   localparam logic [9:0] SW_OFF = 10'd0;
   localparam logic [9:0] SW_ON  = 10'd1;

   localparam logic [11:0] STEP       = 12'd10;
   localparam logic [7:0]  FULL_LEVEL = 8'd255;
   localparam logic [11:0] DUTY_MAX   = 12'd2550;

   typedef struct packed {
      logic        on;
      logic [7:0]  level;
      logic [11:0] duty;
   } chan_state_type;

   typedef struct packed {
      logic        on;
      logic [7:0]  level;
      logic        report;
   } cmd_result_type;

   typedef struct packed {
      logic [11:0] duty;
      logic        moved;
   } fade_result_type;

endpackage

@@ rtl/core/tcdf_if.sv @@
interface tcdf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       channel;
   logic [9:0] value;

   modport source (output valid, output op, output channel, output value, input ready);
   modport sink (input valid, input op, input channel, input value, output ready);
endinterface

interface tcdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] duty_first;
   logic [11:0] duty_second;
   logic        on_first;
   logic        on_second;
   logic [7:0]  level_first;
   logic [7:0]  level_second;
   logic        report;
   logic        duty_moved;

   modport source (
      output valid, output duty_first, output duty_second, output on_first,
      output on_second, output level_first, output level_second, output report,
      output duty_moved, input ready
   );
   modport sink (
      input valid, input duty_first, input duty_second, input on_first,
      input on_second, input level_first, input level_second, input report,
      input duty_moved, output ready
   );
endinterface

@@ rtl/core/two_channel_dimmer_fade.sv @@
// Channel  Direction  Handshake          Payload
// req_if   in         valid / ready      op, channel, value
// rsp_if   out        valid / ready      duty, on flag and level of both channels,
//                                        report, duty_moved
//
// Each request gives exactly one response via the input and output registers.
// One request is taken every cycle unless the output stalls; the state update is a
// single pass through the fade step and command decode between the input and
// output registers. Synchronous active-high reset clears both channels to off,
// level 0 and duty 0. A stalled response holds the output register; requests keep
// flowing until the input register is also full.
module two_channel_dimmer_fade (
   input logic        clock,
   input logic        reset,
   tcdf_req_if.sink   req_if,
   tcdf_rsp_if.source rsp_if
);
   import tcdf_pkg::*;

   logic        in_valid_ff, in_valid_in;
   op_type      in_op_ff;
   logic        in_channel_ff;
   logic [9:0]  in_value_ff;

   logic        out_valid_ff, out_valid_in;
   chan_state_type out_state_ff [2];
   logic        out_report_ff, out_report_in;
   logic        out_moved_ff, out_moved_in;

   chan_state_type  state_ff [2];
   chan_state_type  state_in [2];
   fade_result_type fade [2];
   cmd_result_type  cmd [2];

   logic advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign in_valid_in = (req_if.valid && req_if.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   for (genvar ch = 0; ch < 2; ch++) begin : g_chan
      tcdf_fade u_fade (
         .state (state_ff[ch]),
         .fade  (fade[ch])
      );
      tcdf_cmd u_cmd (
         .state (state_ff[ch]),
         .op    (in_op_ff),
         .sel   (in_channel_ff == 1'(ch)),
         .value (in_value_ff),
         .cmd   (cmd[ch])
      );

      always_comb begin
         state_in[ch] = state_ff[ch];
         if (advance) begin
            if (in_op_ff == OP_TICK) begin
               state_in[ch].duty = fade[ch].duty;
            end else begin
               state_in[ch].on = cmd[ch].on;
               state_in[ch].level = cmd[ch].level;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            state_ff[ch] <= '0;
         end else begin
            state_ff[ch] <= state_in[ch];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            out_state_ff[ch] <= state_in[ch];
         end
      end
   end

   assign out_report_in = (in_op_ff != OP_TICK) && (cmd[0].report || cmd[1].report);
   assign out_moved_in = (in_op_ff == OP_TICK) && (fade[0].moved || fade[1].moved);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_op_ff <= req_if.op;
         in_channel_ff <= req_if.channel;
         in_value_ff <= req_if.value;
      end
      if (advance) begin
         out_report_ff <= out_report_in;
         out_moved_ff <= out_moved_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.duty_first = out_state_ff[0].duty;
   assign rsp_if.duty_second = out_state_ff[1].duty;
   assign rsp_if.on_first = out_state_ff[0].on;
   assign rsp_if.on_second = out_state_ff[1].on;
   assign rsp_if.level_first = out_state_ff[0].level;
   assign rsp_if.level_second = out_state_ff[1].level;
   assign rsp_if.report = out_report_ff;
   assign rsp_if.duty_moved = out_moved_ff;

   a_report_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_report_ff && out_moved_ff))
      else $error("report and duty_moved set together");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff[0].duty <= DUTY_MAX) && (state_ff[1].duty <= DUTY_MAX))
      else $error("duty above full scale");

   a_duty_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_op_ff != OP_TICK))
      |=> ($stable(state_ff[0].duty) && $stable(state_ff[1].duty)))
      else $error("duty changed on a command");

   a_level_only_on_cmd: assert property (@(posedge clock) disable iff (reset)
      (!advance || (in_op_ff == OP_TICK))
      |=> ($stable(state_ff[0].level) && $stable(state_ff[1].level)
           && $stable(state_ff[0].on) && $stable(state_ff[1].on)))
      else $error("channel setting changed without a command");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_if.ready)
      else $error("request refused with empty output register");

endmodule

@@ rtl/core/tcdf_fade.sv @@
module tcdf_fade (
   input  tcdf_pkg::chan_state_type  state,
   output tcdf_pkg::fade_result_type fade
);
   import tcdf_pkg::*;

   logic [11:0] goal;
   logic [11:0] level_wide;
   logic [12:0] sum;
   logic [11:0] next;

   always_comb begin
      level_wide = {4'b0000, state.level};
      goal = state.on ? ((level_wide << 3) + (level_wide << 1)) : 12'd0;
      sum = {1'b0, state.duty} + {1'b0, STEP};
      next = state.duty;
      if (state.duty > goal) begin
         next = (state.duty >= STEP) ? (state.duty - STEP) : 12'd0;
      end else if (state.duty < goal) begin
         next = (sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : sum[11:0];
      end
      if (next > DUTY_MAX) begin
         next = DUTY_MAX;
      end
      fade.duty = next;
      fade.moved = (next != state.duty);
   end

endmodule

@@ rtl/core/tcdf_cmd.sv @@
module tcdf_cmd (
   input  tcdf_pkg::chan_state_type state,
   input  tcdf_pkg::op_type         op,
   input  logic                     sel,
   input  logic [9:0]               value,
   output tcdf_pkg::cmd_result_type cmd
);
   import tcdf_pkg::*;

   always_comb begin
      cmd.on = state.on;
      cmd.level = state.level;
      cmd.report = 1'b0;
      if (sel) begin
         case (op)
            OP_SWITCH: begin
               if (value == SW_OFF) begin
                  cmd.on = 1'b0;
                  cmd.report = 1'b1;
               end else if (value == SW_ON) begin
                  if (state.level == 8'd0) begin
                     cmd.level = FULL_LEVEL;
                  end
                  cmd.on = 1'b1;
                  cmd.report = 1'b1;
               end
            end
            OP_LEVEL: begin
               if (value <= {2'b00, FULL_LEVEL}) begin
                  cmd.level = value[7:0];
                  cmd.on = 1'b1;
                  cmd.report = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
